// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the key encoder RTL.
// Included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication.
`define CHK_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ===== rtl/kenc_pkg.sv =====
// Package for the key event encoder: payload structs, action codes, helpers.
// No dependencies.
`default_nettype none
package kenc_pkg;
  typedef struct packed {
    logic       cmd;
    logic [7:0] key_code;
    logic [8:0] scan_code;
    logic       shift_held;
    logic       alt_held;
    logic       ctrl_held;
    logic       app_cursor_mode;
    logic       newline_mode;
    logic       on_alternate_screen;
    logic       layout_has_text;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic [3:0]  action;
    logic [2:0]  scroll_kind;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    ACT_SEND = 4'd0, ACT_CONSUMED = 4'd1, ACT_UNHANDLED = 4'd2, ACT_CLOSE = 4'd3,
    ACT_SYSMENU = 4'd4, ACT_CTXMENU = 4'd5, ACT_COPY = 4'd6, ACT_PASTE = 4'd7,
    ACT_SCROLL = 4'd8, ACT_FULLSCREEN = 4'd9, ACT_LAYOUT = 4'd10
  } action_t;

  typedef enum logic [1:0] {
    NP_NONE = 2'd0, NP_ALONE = 2'd1, NP_OCT = 2'd2, NP_DEC = 2'd3
  } np_state_t;

  localparam logic [2:0] CFG_BS_DEL = 3'd0;
  localparam logic [2:0] CFG_ESC_FS = 3'd1;
  localparam logic [2:0] CFG_CLOSE_F4 = 3'd2;
  localparam logic [2:0] CFG_LONE_ALT = 3'd3;
  localparam logic [2:0] CFG_SCROLL_MODS = 3'd4;

  localparam int QueueDepth = 2;
  localparam int MaxBytes = 7;

  // Classified event: up to seven bytes or a single action.
  typedef struct packed {
    logic [6:0][15:0] bytes;
    logic [2:0]       count;   // number of items, 1..7
    logic [3:0]       action;
    logic [2:0]       scroll_kind;
  } job_t;

  function automatic logic [7:0] fkey_code(input logic [4:0] idx);
    logic [7:0] r;
    case (idx)
      5'd0: r = 8'd15;  5'd1: r = 8'd17;  5'd2: r = 8'd18;  5'd3: r = 8'd19;
      5'd4: r = 8'd20;  5'd5: r = 8'd21;  5'd6: r = 8'd23;  5'd7: r = 8'd24;
      5'd8: r = 8'd25;  5'd9: r = 8'd26;  5'd10: r = 8'd28; 5'd11: r = 8'd29;
      5'd12: r = 8'd31; 5'd13: r = 8'd32; 5'd14: r = 8'd33; 5'd15: r = 8'd34;
      5'd16: r = 8'd36; 5'd17: r = 8'd37; 5'd18: r = 8'd38; 5'd19: r = 8'd39;
      default: r = 8'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/kenc_front.sv =====
// Front end: accepts key events, keeps Alt+numpad state, builds a job.
// Depends on kenc_pkg.
`default_nettype none
module kenc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire kenc_pkg::in_item_t in_data,
  input  wire logic              bs_del,
  input  wire logic              esc_fs,
  input  wire logic              close_f4,
  input  wire logic              lone_alt,
  input  wire logic [2:0]        scroll_mods,
  output logic                   job_valid,
  input  wire logic              job_ready,
  output kenc_pkg::job_t         job
);
  import kenc_pkg::*;

  np_state_t   np_state, np_state_next;
  logic [15:0] np_value, np_value_next;
  job_t        job_c;

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign job       = job_c;

  always_comb begin
    logic [2:0]  mods;
    logic [7:0]  key, digit, c, code, mch;
    logic [15:0] mul;
    logic        done, hasc;
    logic [2:0]  n;
    logic [6:0][15:0] b;
    mods = {in_data.ctrl_held, in_data.alt_held, in_data.shift_held};
    key = in_data.key_code;
    digit = key - 8'h60;
    mch = 8'h31 + {5'd0, mods};
    np_state_next = np_state;
    np_value_next = np_value;
    job_c = '0;
    done = 1'b0;
    n = 3'd0;
    b = '0;
    c = 8'd0;
    code = 8'd0;
    hasc = 1'b0;
    mul = (np_state == NP_OCT) ? {np_value[12:0], 3'b000}
                               : ({np_value[12:0], 3'b000} + {np_value[14:0], 1'b0});
    if (in_data.cmd) begin
      done = 1'b1;
      job_c.count = 3'd1;
      if (key != 8'h12) job_c.action = ACT_UNHANDLED;
      else if (np_state == NP_NONE) job_c.action = ACT_CONSUMED;
      else if (np_state == NP_ALONE) begin
        np_state_next = NP_NONE;
        if (lone_alt) begin
          job_c.action = ACT_SEND;
          job_c.bytes[0] = 16'h1B;
        end else job_c.action = ACT_CONSUMED;
      end else begin
        np_state_next = NP_NONE;
        job_c.action = ACT_SEND;
        job_c.bytes[0] = np_value;
      end
    end else begin
      if (np_state == NP_ALONE && digit < 8'd10) begin
        np_value_next = {8'd0, digit};
        np_state_next = (digit != 8'd0) ? NP_DEC : NP_OCT;
        done = 1'b1;
      end else if ((np_state == NP_OCT && digit < 8'd8) ||
                   (np_state == NP_DEC && digit < 8'd10)) begin
        np_value_next = mul + {8'd0, digit};
        done = 1'b1;
      end else begin
        np_state_next = (key == 8'h12 && !in_data.shift_held && !in_data.ctrl_held)
                        ? NP_ALONE : NP_NONE;
        if (np_state_next == NP_ALONE) done = 1'b1;
      end
      job_c.count = 3'd1;
      job_c.action = ACT_CONSUMED;
      if (!done) begin
        done = 1'b1;
        if (in_data.alt_held && !in_data.ctrl_held && key == 8'h73 && close_f4)
          job_c.action = ACT_CLOSE;
        else if (in_data.alt_held && !in_data.ctrl_held && key == 8'h20)
          job_c.action = ACT_SYSMENU;
        else if (key == 8'h5D) job_c.action = ACT_CTXMENU;
        else if (key == 8'h2D && mods == 3'd4) job_c.action = ACT_COPY;
        else if (key == 8'h2D && mods == 3'd1) job_c.action = ACT_PASTE;
        else if (!in_data.on_alternate_screen && mods == scroll_mods &&
                 (key == 8'h24 || key == 8'h23 || key == 8'h21 || key == 8'h22 ||
                  key == 8'h26 || key == 8'h28)) begin
          job_c.action = ACT_SCROLL;
          case (key)
            8'h24: job_c.scroll_kind = 3'd0;
            8'h23: job_c.scroll_kind = 3'd1;
            8'h21: job_c.scroll_kind = 3'd2;
            8'h22: job_c.scroll_kind = 3'd3;
            8'h26: job_c.scroll_kind = 3'd4;
            default: job_c.scroll_kind = 3'd5;
          endcase
        end else done = 1'b0;
      end
      if (!done && in_data.alt_held) begin
        done = 1'b1;
        case (key)
          8'h1B, 8'h13, 8'h03, 8'h09: job_c.action = ACT_UNHANDLED;
          8'h0D: job_c.action = in_data.ctrl_held ? ACT_UNHANDLED : ACT_FULLSCREEN;
          8'h08: begin
            if (in_data.ctrl_held) job_c.action = ACT_UNHANDLED;
            else begin
              b[0] = 16'h1B;
              b[1] = in_data.shift_held ? 16'h20 : (bs_del ? 16'h7F : 16'h08);
              n = 3'd2;
            end
          end
          default: done = 1'b0;
        endcase
      end else if (!done) begin
        done = 1'b1;
        case (key)
          8'h1B: begin
            b[0] = in_data.shift_held ? 16'h1D : (esc_fs ? 16'h1C : 16'h1B);
            n = 3'd1;
          end
          8'h13, 8'h03: begin
            c = (key == 8'h13) ? 8'h1D : 8'h1C;
            if (in_data.shift_held) begin
              b[0] = 16'h1B; b[1] = {8'd0, c}; n = 3'd2;
            end else begin
              b[0] = {8'd0, c}; n = 3'd1;
            end
            c = 8'd0;
          end
          8'h09: begin
            if (in_data.ctrl_held) begin
              b[0] = 16'h1B; b[1] = in_data.shift_held ? 16'h5B : 16'h4F;
              b[2] = 16'h7A; n = 3'd3;
            end else if (in_data.shift_held) begin
              b[0] = 16'h1B; b[1] = 16'h5B; b[2] = 16'h5A; n = 3'd3;
            end else begin
              b[0] = 16'h09; n = 3'd1;
            end
          end
          8'h0D: begin
            if (in_data.ctrl_held) begin
              if (in_data.shift_held) begin
                b[0] = 16'h1B; b[1] = 16'h1E; n = 3'd2;
              end else begin
                b[0] = 16'h1E; n = 3'd1;
              end
            end else if (in_data.shift_held) begin
              b[0] = 16'h0A; n = 3'd1;
            end else if (in_data.newline_mode) begin
              b[0] = 16'h0D; b[1] = 16'h0A; n = 3'd2;
            end else begin
              b[0] = 16'h0D; n = 3'd1;
            end
          end
          8'h08: begin
            if (in_data.ctrl_held) begin
              if (in_data.shift_held) begin
                b[0] = 16'h1B; b[1] = bs_del ? 16'h1F : 16'h7F; n = 3'd2;
              end else begin
                b[0] = bs_del ? 16'h1F : 16'h7F; n = 3'd1;
              end
            end else begin
              b[0] = bs_del ? 16'h7F : 16'h08; n = 3'd1;
            end
          end
          default: done = 1'b0;
        endcase
      end
      if (!done) begin
        done = 1'b1;
        c = 8'd0;
        case (key)
          8'h26: c = 8'h41; 8'h28: c = 8'h42; 8'h27: c = 8'h43; 8'h25: c = 8'h44;
          8'h0C: c = 8'h45; 8'hA7: c = 8'h46; 8'hA6: c = 8'h47;
          default: c = 8'd0;
        endcase
        if (c != 8'd0) begin
          b[0] = 16'h1B;
          if (mods == 3'd0) begin
            b[1] = in_data.app_cursor_mode ? 16'h4F : 16'h5B;
            b[2] = {8'd0, c}; n = 3'd3;
          end else begin
            b[1] = 16'h5B; b[2] = 16'h31; b[3] = 16'h3B; b[4] = {8'd0, mch};
            b[5] = {8'd0, c}; n = 3'd6;
          end
        end else begin
          case (key)
            8'h21: c = 8'h35; 8'h22: c = 8'h36; 8'h24: c = 8'h31;
            8'h23: c = 8'h34; 8'h2D: c = 8'h32; 8'h2E: c = 8'h33;
            default: c = 8'd0;
          endcase
          if (c != 8'd0) begin
            b[0] = 16'h1B; b[1] = 16'h5B; b[2] = {8'd0, c};
            if (mods != 3'd0) begin
              b[3] = 16'h3B; b[4] = {8'd0, mch}; b[5] = 16'h7E; n = 3'd6;
            end else begin
              b[3] = 16'h7E; n = 3'd4;
            end
          end else if (key >= 8'h70 && key <= 8'h73) begin
            c = key - 8'h70 + 8'h50;
            b[0] = 16'h1B;
            if (mods == 3'd0) begin
              b[1] = 16'h4F; b[2] = {8'd0, c}; n = 3'd3;
            end else begin
              b[1] = 16'h5B; b[2] = 16'h31; b[3] = 16'h3B; b[4] = {8'd0, mch};
              b[5] = {8'd0, c}; n = 3'd6;
            end
          end else if (key >= 8'h74 && key <= 8'h87) begin
            code = fkey_code(5'(key - 8'h74));
            b[0] = 16'h1B; b[1] = 16'h5B;
            b[2] = (code >= 8'd30) ? 16'h33 : (code >= 8'd20) ? 16'h32 : 16'h31;
            b[3] = {8'd0, 8'h30 + ((code >= 8'd30) ? code - 8'd30 :
                                    (code >= 8'd20) ? code - 8'd20 : code - 8'd10)};
            if (mods != 3'd0) begin
              b[4] = 16'h3B; b[5] = {8'd0, mch}; b[6] = 16'h7E; n = 3'd7;
            end else begin
              b[4] = 16'h7E; n = 3'd5;
            end
          end else if (key == 8'h20 && mods == 3'd4) begin
            b[0] = 16'h00; n = 3'd1;
          end else if (in_data.layout_has_text) begin
            job_c.action = ACT_LAYOUT;
          end else if (!in_data.ctrl_held) begin
            job_c.action = ACT_UNHANDLED;
          end else begin
            hasc = 1'b1;
            if (key >= 8'h30 && key <= 8'h39) c = key;
            else if (key >= 8'h60 && key <= 8'h69) c = key - 8'h30;
            else if (key >= 8'h6A && key <= 8'h6F) c = key - 8'h40;
            else if (key >= 8'hBB && key <= 8'hBE) c = key - 8'h90;
            else hasc = 1'b0;
            if (hasc) begin
              b[0] = 16'h1B;
              b[1] = (in_data.alt_held || in_data.shift_held) ? 16'h5B : 16'h4F;
              b[2] = {8'd0, c + 8'h40}; n = 3'd3;
            end else begin
              hasc = 1'b1;
              if (key == 8'h20 || (key >= 8'h41 && key <= 8'h5A)) c = key;
              else begin
                case (in_data.scan_code)
                  9'h2B, 9'h56: c = 8'h5C;
                  9'h1A: c = 8'h5B;
                  9'h1B: c = 8'h5D;
                  9'h28: c = 8'h5E;
                  9'h35: c = 8'h5F;
                  default: hasc = 1'b0;
                endcase
              end
              if (!hasc) job_c.action = ACT_UNHANDLED;
              else if (in_data.alt_held || in_data.shift_held) begin
                b[0] = 16'h1B; b[1] = {11'd0, c[4:0]}; n = 3'd2;
              end else begin
                b[0] = {11'd0, c[4:0]}; n = 3'd1;
              end
            end
          end
        end
      end
      if (n != 3'd0) begin
        job_c.action = ACT_SEND;
        job_c.bytes = b;
        job_c.count = n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      np_state <= NP_NONE;
      np_value <= '0;
    end else if (in_valid && in_ready) begin
      np_state <= np_state_next;
      np_value <= np_value_next;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/kenc_queue.sv =====
// Small job FIFO between the front end and the byte sequencer.
// Depends on kenc_pkg.
`default_nettype none
module kenc_queue #(
  parameter int Depth = kenc_pkg::QueueDepth
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_valid,
  output logic                 wr_ready,
  input  wire kenc_pkg::job_t  wr_data,
  output logic                 rd_valid,
  input  wire logic            rd_ready,
  output kenc_pkg::job_t       rd_data
);
  import kenc_pkg::*;
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

  job_t           mem [Depth];
  logic [Aw-1:0]  wptr, rptr;
  logic [Aw:0]    cnt;
  logic           wr_en, rd_en;

  assign wr_ready = (cnt != (Aw+1)'(Depth));
  assign rd_valid = (cnt != '0);
  assign rd_data  = mem[rptr];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (wr_en) wptr <= (wptr == Aw'(Depth - 1)) ? '0 : wptr + Aw'(1);
      if (rd_en) rptr <= (rptr == Aw'(Depth - 1)) ? '0 : rptr + Aw'(1);
      cnt <= cnt + (Aw+1)'(wr_en) - (Aw+1)'(rd_en);
    end
  end

  `include "assert_macros.svh"
  `CHK_IMPL(a_cnt_bound, clk, rst, 1'b1, cnt <= (Aw+1)'(Depth), "queue count overflow")
  `CHK_NEXT(a_full_hold, clk, rst, (!rd_en && wr_en && cnt == (Aw+1)'(Depth - 1)), !wr_ready, "queue full not flagged")
endmodule
`default_nettype wire

// ===== rtl/kenc_back.sv =====
// Back end: plays one job out as result transactions, one per cycle while out_ready is high.
// Depends on kenc_pkg.
`default_nettype none
module kenc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              job_valid,
  output logic                   job_ready,
  input  wire kenc_pkg::job_t    job,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output kenc_pkg::out_item_t    out_data
);
  import kenc_pkg::*;

  logic [2:0] idx;
  logic       last_c;

  assign last_c    = (idx + 3'd1 == job.count);
  assign out_valid = job_valid;
  assign job_ready = out_ready && last_c;
  assign out_data.code_unit   = job.bytes[idx];
  assign out_data.action      = job.action;
  assign out_data.scroll_kind = job.scroll_kind;
  assign out_data.last        = last_c;

  always_ff @(posedge clk) begin
    if (rst) idx <= '0;
    else if (out_valid && out_ready) idx <= last_c ? 3'd0 : idx + 3'd1;
  end

  `include "assert_macros.svh"
  `CHK_IMPL(a_idx_range, clk, rst, job_valid, idx < job.count, "byte index past job end")
endmodule
`default_nettype wire

// ===== rtl/key_event_to_vt_sequence_encoder_top.sv =====
// Key event encoder: turns key-down/up events into xterm-style byte
// sequences or single action codes. An event is classified in the cycle it is
// accepted and queued; the sequencer then emits its results (1 to 7) one per
// cycle while out_ready is high. Input is taken while the queue (QDepth jobs,
// two by default) has room.
// Depends on kenc_pkg, kenc_front, kenc_queue, kenc_back.
`default_nettype none
module key_event_to_vt_sequence_encoder_top #(
  parameter int QDepth = kenc_pkg::QueueDepth
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire kenc_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output kenc_pkg::out_item_t       out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [2:0]           cfg_data
);
  import kenc_pkg::*;

  logic       bs_del, esc_fs, close_f4, lone_alt;
  logic [2:0] scroll_mods;
  logic       fj_valid, fj_ready, bj_valid, bj_ready;
  job_t       fjob, bjob;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bs_del <= 1'b0; esc_fs <= 1'b0; close_f4 <= 1'b1; lone_alt <= 1'b0;
      scroll_mods <= 3'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BS_DEL:      bs_del <= cfg_data[0];
        CFG_ESC_FS:      esc_fs <= cfg_data[0];
        CFG_CLOSE_F4:    close_f4 <= cfg_data[0];
        CFG_LONE_ALT:    lone_alt <= cfg_data[0];
        CFG_SCROLL_MODS: scroll_mods <= cfg_data;
        default: ;
      endcase
    end
  end

  kenc_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .bs_del, .esc_fs, .close_f4, .lone_alt, .scroll_mods,
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fjob)
  );

  kenc_queue #(.Depth(QDepth)) u_queue (
    .clk, .rst, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fjob),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bjob)
  );

  kenc_back u_back (
    .clk, .rst, .job_valid(bj_valid), .job_ready(bj_ready), .job(bjob),
    .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire
